// ===== rtl/i8dq_pkg.sv =====
// Shared types, codes and constants for the int8 row-wise dequantizer.
// It includes the fp16-to-fp32 widening function. It depends on nothing else.
`default_nettype none
package i8dq_pkg;

  // Item kinds on the input channel.
  localparam logic [1:0] KIND_ELEM   = 2'd0;
  localparam logic [1:0] KIND_APPEND = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_ROW_COUNT  = 2'd0;
  localparam logic [1:0] REG_HEAD_WIDTH = 2'd1;

  // This is 1e-8 in fp32. It stands in for a zero row scale.
  localparam logic [31:0] SMALL_SCALE = 32'h322BCC77;
  localparam logic [31:0] QNAN_BITS   = 32'h7FC00000;

  typedef logic [15:0] half_t;
  typedef logic [31:0] single_t;

  // Widen fp16 to fp32 exactly. Subnormals are normalized and NaNs are made quiet.
  function automatic single_t half_to_single(input half_t h);
    logic [4:0] ex;
    logic [9:0] man;
    logic [3:0] p;
    logic [9:0] nm;
    logic [7:0] e32;
    single_t    r;
    ex  = h[14:10];
    man = h[9:0];
    p   = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (man[i]) p = 4'(i);
    end
    nm  = man << (4'd10 - p);
    e32 = 8'd103 + {4'd0, p};
    if (ex == 5'd0) begin
      if (man == 10'd0) r = {h[15], 31'd0};
      else r = {h[15], e32, nm, 13'd0};
    end else if (ex == 5'd31) begin
      if (man == 10'd0) r = {h[15], 8'hFF, 23'd0};
      else r = {h[15], 8'hFF, 1'b1, man[8:0], 13'd0};
    end else begin
      r = {h[15], 3'd0, ex, man, 13'd0} + {1'b0, 8'd112, 23'd0};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/int8_rowwise_dequant_with_outliers.sv =====
// Top level of the int8 row-wise dequantizer with an outlier table.
// It instantiates i8dq_otab and i8dq_fmul, and it uses i8dq_pkg.
//
//   Channel  Handshake               Payload
//   in_      in_valid / in_stall     kind, row_index, column_index, quant_value, half_word
//   out_     out_valid / out_stall   value_bits, out_column, from_outlier
//   cfg_     cfg_valid / cfg_ready   cfg_index, cfg_data
//
// An element item is compared with every loaded entry, one read per cycle through the
// table's single read port, and the last match wins. Its result is registered when the scan
// ends, and the block takes no new item until then. Appends, clears and dropped elements do
// not stall the input. A result sits in the output register while a new item is taken; if
// that register is still full, the finished result waits in the core. Reset (rst_n low,
// synchronous) empties the table.
`default_nettype none
module int8_rowwise_dequant_with_outliers #(
  parameter int OUTLIER_DEPTH = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_kind,
  input  wire logic [15:0]        in_row_index,
  input  wire logic [15:0]        in_column_index,
  input  wire logic signed [7:0]  in_quant_value,
  input  wire logic [15:0]        in_half_word,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [31:0]             out_value_bits,
  output logic [15:0]             out_out_column,
  output logic                    out_from_outlier,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);
  import i8dq_pkg::*;

  localparam int AW = (OUTLIER_DEPTH > 1) ? $clog2(OUTLIER_DEPTH) : 1;
  localparam int FW = $clog2(OUTLIER_DEPTH + 1);
  localparam logic [FW-1:0] DEPTH_CNT = FW'(OUTLIER_DEPTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_OUTQ = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [FW-1:0] fill_r, cnt_r;
  logic [15:0]   row_count_r;
  logic [12:0]   head_width_r;
  logic [15:0]   row_r, col_r;
  logic          rd_pend_r, hit_r;
  half_t         hit_val_r;
  logic          accept, rd_en, wr_en, elem_ok;
  logic [47:0]   rd_data;
  single_t       mul_res;
  logic          out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid & ~in_stall;
  assign out_free  = ~out_valid | ~out_stall;
  assign elem_ok   = (in_row_index < row_count_r) &&
                     (in_column_index < {3'd0, head_width_r});
  assign wr_en     = accept && in_kind == KIND_APPEND && fill_r < DEPTH_CNT;
  assign rd_en     = (state_r == ST_SCAN) && (cnt_r < fill_r);

  i8dq_otab #(.DEPTH(OUTLIER_DEPTH), .AW(AW)) u_otab (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (fill_r[AW-1:0]),
    .wr_data ({in_row_index, in_column_index, in_half_word}),
    .rd_en   (rd_en),
    .rd_addr (cnt_r[AW-1:0]),
    .rd_data (rd_data)
  );

  i8dq_fmul u_fmul (
    .clk    (clk),
    .ld     (accept),
    .quant  (in_quant_value),
    .scale  (in_half_word),
    .result (mul_res)
  );

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept && in_kind == KIND_ELEM && elem_ok) state_nxt = ST_SCAN;
      ST_SCAN: if (!rd_en && !rd_pend_r) state_nxt = out_free ? ST_IDLE : ST_OUTQ;
      ST_OUTQ: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state, configuration and the table fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      fill_r       <= '0;
      row_count_r  <= 16'd0;
      head_width_r <= 13'd128;
      rd_pend_r    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= rd_en;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_ROW_COUNT) row_count_r <= cfg_data;
        else if (cfg_index == REG_HEAD_WIDTH) head_width_r <= cfg_data[12:0];
      end
      if (wr_en) fill_r <= fill_r + FW'(1);
      else if (accept && in_kind == KIND_CLEAR) fill_r <= '0;
      if ((state_r == ST_SCAN || state_r == ST_OUTQ) && state_nxt == ST_IDLE) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  // Scan the table and keep the last match.
  always_ff @(posedge clk) begin
    if (accept) begin
      row_r <= in_row_index;
      col_r <= in_column_index;
      cnt_r <= '0;
      hit_r <= 1'b0;
    end else begin
      if (rd_en) cnt_r <= cnt_r + FW'(1);
      if (rd_pend_r && rd_data[47:32] == row_r && rd_data[31:16] == col_r) begin
        hit_r     <= 1'b1;
        hit_val_r <= rd_data[15:0];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if ((state_r == ST_SCAN || state_r == ST_OUTQ) && state_nxt == ST_IDLE) begin
      out_value_bits   <= hit_r ? half_to_single(hit_val_r) : mul_res;
      out_out_column   <= col_r;
      out_from_outlier <= hit_r;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/i8dq_otab.sv =====
// Outlier table memory: it holds row, column and fp16 value per entry.
// It has one write port and one read port with a registered read. It uses i8dq_pkg.
`default_nettype none
module i8dq_otab #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [47:0]   wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic [47:0]        rd_data
);
  import i8dq_pkg::*;

  logic [47:0] mem_r [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_addr] <= wr_data;
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem_r[rd_addr];
  end
endmodule
`default_nettype wire

// ===== rtl/i8dq_fmul.sv =====
// The int8 by fp16 scale multiplier. It produces an fp32 result, rounded to nearest even.
// The operand stage is registered, and the rounding and packing follow. It uses i8dq_pkg.
`default_nettype none
module i8dq_fmul (
  input  wire logic                 clk,
  input  wire logic                 ld,
  input  wire logic signed [7:0]    quant,
  input  wire i8dq_pkg::half_t      scale,
  output i8dq_pkg::single_t         result
);
  import i8dq_pkg::*;

  localparam logic [1:0] CLS_NUM  = 2'd0;
  localparam logic [1:0] CLS_ZERO = 2'd1;
  localparam logic [1:0] CLS_INF  = 2'd2;
  localparam logic [1:0] CLS_NAN  = 2'd3;

  single_t     sb, sv;
  logic [7:0]  qmag, qn;
  logic [2:0]  qp;
  logic [23:0] mfull;
  logic [1:0]  cls;
  logic [31:0] prod_r;
  logic [9:0]  exp_r;
  logic        sign_r;
  logic [1:0]  cls_r;

  // Operand decode: the scale is widened, a zero is replaced, and |q| is normalized.
  always_comb begin
    sb = half_to_single(scale);
    sv = (sb[30:0] == 31'd0) ? SMALL_SCALE : sb;
    qmag = quant[7] ? 8'(-quant) : 8'(quant);
    qp = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (qmag[i]) qp = 3'(i);
    end
    qn = qmag << (3'd7 - qp);
    mfull = {1'b1, sv[22:0]};
    if (sv[30:23] == 8'hFF) begin
      if (sv[22:0] != 23'd0 || qmag == 8'd0) cls = CLS_NAN;
      else cls = CLS_INF;
    end else if (qmag == 8'd0) begin
      cls = CLS_ZERO;
    end else begin
      cls = CLS_NUM;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      prod_r <= 32'(mfull * qn);
      exp_r  <= {2'd0, sv[30:23]} + 10'd8 - {7'd0, (3'd7 - qp)};
      sign_r <= quant[7] ^ sv[31];
      cls_r  <= cls;
    end
  end

  // Round to nearest even and pack the result.
  logic [23:0] mant;
  logic        g, st, inc;
  logic [24:0] sum;
  logic [9:0]  ef;
  always_comb begin
    if (prod_r[31]) begin
      mant = prod_r[31:8];
      g    = prod_r[7];
      st   = |prod_r[6:0];
      ef   = exp_r;
    end else begin
      mant = prod_r[30:7];
      g    = prod_r[6];
      st   = |prod_r[5:0];
      ef   = exp_r - 10'd1;
    end
    inc = g & (st | mant[0]);
    sum = {1'b0, mant} + {24'd0, inc};
    if (sum[24]) ef = ef + 10'd1;
    case (cls_r)
      CLS_ZERO: result = {sign_r, 31'd0};
      CLS_INF:  result = {sign_r, 8'hFF, 23'd0};
      CLS_NAN:  result = QNAN_BITS;
      default:  result = {sign_r, ef[7:0], (sum[24] ? sum[23:1] : sum[22:0])};
    endcase
  end
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for int8_rowwise_dequant_with_outliers.
// It uses i8dq_pkg for the item kinds and register indexes. A directed table and
// random phases run; each result is compared with a behavioral prediction or a given value.
`default_nettype none
module testbench;
  import i8dq_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [1:0] REG_SPARE_A = 2'd2;
  localparam logic [1:0] REG_SPARE_B = 2'd3;
  localparam logic [31:0] TINY_SCALE = 32'h322BCC77;
  localparam logic [31:0] QUIET_NAN = 32'h7FC00000;
  localparam int TABLE_DEPTH = 64;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 150;

  // One directed row: the item, plus an expected value when it is obvious.
  typedef struct {
    logic [1:0]        kind;
    logic [15:0]       row;
    logic [15:0]       col;
    logic signed [7:0] q;
    logic [15:0]       half;
    bit                typed;
    logic [31:0]       bits;
    logic              outl;
  } vector_t;

  typedef struct {
    logic [31:0] bits;
    logic [15:0] col;
    logic        outl;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_kind = KIND_ELEM;
  logic [15:0] in_row_index = '0;
  logic [15:0] in_column_index = '0;
  logic signed [7:0] in_quant_value = '0;
  logic [15:0] in_half_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [31:0] out_value_bits;
  logic [15:0] out_out_column;
  logic out_from_outlier;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = REG_ROW_COUNT;
  logic [15:0] cfg_data = '0;

  // Prediction state: the outlier table and the two registers.
  logic [15:0] shadow_row [TABLE_DEPTH];
  logic [15:0] shadow_col [TABLE_DEPTH];
  logic [15:0] shadow_val [TABLE_DEPTH];
  int shadow_fill = 0;
  logic [15:0] shadow_rows = 16'd0;
  logic [12:0] shadow_width = 13'd128;

  result_t pending_results[$];
  int fail_count = 0;
  bit calm = 1'b0;
  bit hold_off = 1'b0;
  int idle_cycles = 0;

  int8_rowwise_dequant_with_outliers uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind),
    .in_row_index(in_row_index), .in_column_index(in_column_index),
    .in_quant_value(in_quant_value), .in_half_word(in_half_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_value_bits(out_value_bits),
    .out_out_column(out_out_column), .out_from_outlier(out_from_outlier),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Exact fp16 to fp32 widening.
  function automatic logic [31:0] widen_half(logic [15:0] h);
    logic [4:0] ex;
    logic [10:0] man;
    logic [7:0] e32;
    ex = h[14:10];
    man = {1'b0, h[9:0]};
    if (ex == 5'd0) begin
      if (man == 11'd0) return {h[15], 31'd0};
      e32 = 8'd113;
      while (!man[10]) begin
        man = man << 1;
        e32 = e32 - 8'd1;
      end
      return {h[15], e32, man[9:0], 13'd0};
    end
    if (ex == 5'd31) begin
      if (man == 11'd0) return {h[15], 8'hFF, 23'd0};
      return {h[15], 31'd0} | QUIET_NAN | {9'd0, man[9:0], 13'd0};
    end
    return {h[15], 8'(ex) + 8'd112, h[9:0], 13'd0};
  endfunction

  // int8 times the widened scale, rounded to nearest even in fp32.
  function automatic logic [31:0] scaled_value(logic signed [7:0] q, logic [15:0] h);
    logic [31:0] s;
    logic sg;
    longint mag, prod, mant, rem, halfway;
    int k, sh, ex;
    s = widen_half(h);
    if (s[30:0] == 31'd0) s = TINY_SCALE;
    sg = q[7] ^ s[31];
    if (s[30:23] == 8'hFF) begin
      if (s[22:0] != 23'd0 || q == 8'sd0) return QUIET_NAN;
      return {sg, 8'hFF, 23'd0};
    end
    if (q == 8'sd0) return {sg, 31'd0};
    mag = q[7] ? -longint'(q) : longint'(q);
    prod = mag * longint'({1'b1, s[22:0]});
    k = 0;
    for (int i = 0; i < 40; i++) if (prod[i]) k = i;
    if (k <= 23) begin
      mant = prod << (23 - k);
    end else begin
      sh = k - 23;
      mant = prod >> sh;
      rem = prod & ((64'd1 << sh) - 1);
      halfway = 64'd1 << (sh - 1);
      if (rem > halfway || (rem == halfway && mant[0])) mant = mant + 1;
      if (mant == (64'd1 << 24)) begin
        mant = mant >> 1;
        k = k + 1;
      end
    end
    ex = int'(s[30:23]) + k - 23;
    return {sg, 8'(ex), mant[22:0]};
  endfunction

  // Apply one accepted item to the shadow state; returns 1 with a result if one is due.
  function automatic bit apply_item(logic [1:0] kind, logic [15:0] row, logic [15:0] col,
                                    logic signed [7:0] q, logic [15:0] h,
                                    output result_t r);
    bit hit;
    logic [15:0] hv;
    hit = 1'b0;
    hv = '0;
    r = '{default: '0};
    case (kind)
      KIND_APPEND: begin
        if (shadow_fill < TABLE_DEPTH) begin
          shadow_row[shadow_fill] = row;
          shadow_col[shadow_fill] = col;
          shadow_val[shadow_fill] = h;
          shadow_fill++;
        end
        return 1'b0;
      end
      KIND_CLEAR: begin
        shadow_fill = 0;
        return 1'b0;
      end
      KIND_ELEM: begin
        if (row >= shadow_rows || 32'(col) >= 32'(shadow_width)) return 1'b0;
        for (int i = 0; i < shadow_fill; i++) begin
          if (shadow_row[i] == row && shadow_col[i] == col) begin
            hit = 1'b1;
            hv = shadow_val[i];
          end
        end
        r.bits = hit ? widen_half(hv) : scaled_value(q, h);
        r.col = col;
        r.outl = hit;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Offer one item and hold it until accepted; queue its expected result.
  task automatic send_item(vector_t v);
    result_t r;
    bit due;
    in_valid <= 1'b1;
    in_kind <= v.kind;
    in_row_index <= v.row;
    in_column_index <= v.col;
    in_quant_value <= v.q;
    in_half_word <= v.half;
    do @(posedge clk); while (in_stall !== 1'b0);
    due = apply_item(v.kind, v.row, v.col, v.q, v.half, r);
    if (v.typed) begin
      if (!due) begin
        $error("directed row expected a result but none is due");
        fail_count++;
      end
      r.bits = v.bits;
      r.outl = v.outl;
    end
    if (due) pending_results.push_back(r);
    if (!calm && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // One register write; the valid drops for a cycle before the next write.
  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    if (idx == REG_ROW_COUNT) shadow_rows = data;
    else if (idx == REG_HEAD_WIDTH) shadow_width = data[12:0];
    @(posedge clk);
  endtask

  // Let the block drain before touching the registers.
  task automatic settle;
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic vector_t row_of(logic [1:0] k, logic [15:0] r, logic [15:0] c,
                                     logic signed [7:0] q, logic [15:0] h,
                                     bit t, logic [31:0] b, logic o);
    vector_t v;
    v.kind = k; v.row = r; v.col = c; v.q = q; v.half = h;
    v.typed = t; v.bits = b; v.outl = o;
    return v;
  endfunction

  // Random item: mostly small coordinates so the table gets hits.
  function automatic vector_t random_item(int clear_pct);
    vector_t v;
    int pick;
    pick = $urandom_range(999);
    if (pick < clear_pct) v.kind = KIND_CLEAR;
    else if (pick < 20) v.kind = KIND_UNUSED;
    else if (pick < 300) v.kind = KIND_APPEND;
    else v.kind = KIND_ELEM;
    if ($urandom_range(3) != 0) begin
      v.row = 16'($urandom_range(7));
      v.col = 16'($urandom_range(7));
    end else begin
      v.row = 16'($urandom);
      v.col = 16'($urandom);
    end
    v.q = 8'($urandom);
    case ($urandom_range(7))
      0: v.half = {1'($urandom), 5'd0, 10'($urandom)};
      1: v.half = {1'($urandom), 5'd31, 10'($urandom_range(1)) << $urandom_range(9)};
      2: v.half = {1'($urandom), 15'd0};
      default: v.half = 16'($urandom);
    endcase
    v.typed = 1'b0;
    v.bits = '0;
    v.outl = 1'b0;
    return v;
  endfunction

  // Result checking.
  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: value_bits %h", out_value_bits);
        fail_count++;
      end else begin
        e = pending_results.pop_front();
        if (out_value_bits !== e.bits) begin
          $error("value_bits expected %h got %h", e.bits, out_value_bits);
          fail_count++;
        end
        if (out_out_column !== e.col) begin
          $error("out_column expected %h got %h", e.col, out_out_column);
          fail_count++;
        end
        if (out_from_outlier !== e.outl) begin
          $error("from_outlier expected %b got %b", e.outl, out_from_outlier);
          fail_count++;
        end
      end
    end
    out_stall <= hold_off || (!calm && $urandom_range(99) < 7);
  end

  // Watchdog on cycles without any accepted item or result.
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
        (cfg_valid && cfg_ready === 1'b1) || !rst_n)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("[int8_rowwise_dequant_with_outliers] ERROR");
      $finish;
    end
  end

  // Long receiver hold-off so the block backs up into its input.
  initial begin
    wait (rst_n);
    repeat (900) @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    vector_t plan[$];
    int rows_cfg [5] = '{100, 65535, 6, 0, 4000};
    int width_cfg [5] = '{128, 4096, 5, 0, 1};
    int clear_cfg [5] = '{40, 2, 60, 40, 1};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_reg(REG_ROW_COUNT, 16'd100);
    write_reg(REG_SPARE_A, 16'hFFFF);
    write_reg(REG_SPARE_B, 16'h0000);

    // Directed part: extremes, special scales, table behavior, dropped items.
    plan.push_back(row_of(KIND_ELEM, 0, 0, 1, 16'h3C00, 1, 32'h3F800000, 0));
    plan.push_back(row_of(KIND_ELEM, 99, 127, -128, 16'h3C00, 1, 32'hC3000000, 0));
    plan.push_back(row_of(KIND_ELEM, 1, 2, 127, 16'h7BFF, 0, 0, 0));
    plan.push_back(row_of(KIND_ELEM, 1, 3, 1, 16'h0000, 1, TINY_SCALE, 0));
    plan.push_back(row_of(KIND_ELEM, 1, 3, -1, 16'h8000, 1, 32'hB22BCC77, 0));
    plan.push_back(row_of(KIND_ELEM, 2, 4, 0, 16'h7C00, 1, QUIET_NAN, 0));
    plan.push_back(row_of(KIND_ELEM, 2, 4, 1, 16'h7C00, 1, 32'h7F800000, 0));
    plan.push_back(row_of(KIND_ELEM, 2, 4, -1, 16'h7C00, 1, 32'hFF800000, 0));
    plan.push_back(row_of(KIND_ELEM, 2, 5, 3, 16'h7E00, 1, QUIET_NAN, 0));
    plan.push_back(row_of(KIND_ELEM, 3, 5, 0, 16'hBC00, 1, 32'h80000000, 0));
    plan.push_back(row_of(KIND_ELEM, 3, 6, 1, 16'h0001, 1, 32'h33800000, 0));
    plan.push_back(row_of(KIND_ELEM, 100, 6, 1, 16'h3C00, 0, 0, 0));
    plan.push_back(row_of(KIND_ELEM, 3, 128, 1, 16'h3C00, 0, 0, 0));
    plan.push_back(row_of(KIND_ELEM, 16'hFFFF, 16'hFFFF, -1, 16'hFFFF, 0, 0, 0));
    plan.push_back(row_of(KIND_APPEND, 5, 7, 0, 16'h4000, 0, 0, 0));
    plan.push_back(row_of(KIND_ELEM, 5, 7, 9, 16'h3C00, 1, 32'h40000000, 1));
    plan.push_back(row_of(KIND_APPEND, 5, 7, 0, 16'h4200, 0, 0, 0));
    plan.push_back(row_of(KIND_ELEM, 5, 7, 9, 16'h3C00, 1, 32'h40400000, 1));
    plan.push_back(row_of(KIND_APPEND, 5, 8, 0, 16'h7C01, 0, 0, 0));
    plan.push_back(row_of(KIND_ELEM, 5, 8, 9, 16'h3C00, 1, 32'h7FC02000, 1));
    plan.push_back(row_of(KIND_APPEND, 1, 1, 0, 16'hFC00, 0, 0, 0));
    plan.push_back(row_of(KIND_ELEM, 1, 1, 4, 16'h3C00, 1, 32'hFF800000, 1));
    plan.push_back(row_of(KIND_UNUSED, 5, 7, 9, 16'h3C00, 0, 0, 0));
    plan.push_back(row_of(KIND_CLEAR, 0, 0, 0, 16'h0000, 0, 0, 0));
    plan.push_back(row_of(KIND_ELEM, 5, 7, 2, 16'h3C00, 1, 32'h40000000, 0));
    foreach (plan[i]) send_item(plan[i]);

    // Random phases over several register settings, extremes included.
    for (int ph = 0; ph < 5; ph++) begin
      settle();
      write_reg(REG_ROW_COUNT, 16'(rows_cfg[ph]));
      write_reg(REG_HEAD_WIDTH, 16'(width_cfg[ph]));
      for (int n = 0; n < (ph == 3 ? 100 : 400); n++) begin
        calm = (ph == 1 && n >= 100 && n < 300);
        send_item(random_item(clear_cfg[ph]));
      end
      calm = 1'b0;
    end

    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("[int8_rowwise_dequant_with_outliers] OK");
    else $display("[int8_rowwise_dequant_with_outliers] ERROR");
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/i8dq_pkg.sv
rtl/i8dq_otab.sv
rtl/i8dq_fmul.sv
rtl/int8_rowwise_dequant_with_outliers.sv
tb/testbench.sv
